// File: rtl/stochastic_rectangle_splitter_core_defines.svh
// Assertion macros used by the rectangle splitter checker.
`ifndef STOCHASTIC_RECTANGLE_SPLITTER_CORE_DEFINES_SVH
`define STOCHASTIC_RECTANGLE_SPLITTER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define SRS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define SRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/srs_pkg.sv
// Types, constants and the containment test of the rectangle splitter.
`default_nettype none

package srs_pkg;

    localparam int DEF_MAX_RECTS = 256;
    localparam int FRAC_BITS     = 16;
    localparam int PT_W          = FRAC_BITS;
    localparam int COORD_W       = FRAC_BITS + 1;
    localparam int IDX_W         = 8;
    localparam int USED_W        = 9;
    localparam int STATUS_W      = 2;

    localparam int IN_TDATA_W    = 2 * PT_W;
    localparam int OUT_FIELDS_W  = IDX_W + 4 * COORD_W + USED_W;
    localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W     = OUT_TDATA_W - OUT_FIELDS_W;

    // Bit offsets of the result fields in tdata
    localparam int OFS_IDX       = 0;
    localparam int OFS_LX        = OFS_IDX + IDX_W;
    localparam int OFS_BY        = OFS_LX + COORD_W;
    localparam int OFS_RX        = OFS_BY + COORD_W;
    localparam int OFS_TY        = OFS_RX + COORD_W;
    localparam int OFS_USED      = OFS_TY + COORD_W;

    localparam logic [COORD_W-1:0] COORD_ZERO = '0;
    localparam logic [COORD_W-1:0] COORD_ONE  = COORD_W'(1) << FRAC_BITS;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [COORD_W-1:0] lx;
        logic [COORD_W-1:0] by;
        logic [COORD_W-1:0] rx;
        logic [COORD_W-1:0] ty;
    } t_rect;

    localparam t_rect UNIT_RECT = '{lx: COORD_ZERO, by: COORD_ZERO,
                                    rx: COORD_ONE, ty: COORD_ONE};

    // Strict containment: a point on an edge is in no rectangle.
    function automatic logic rect_holds(input t_rect r,
                                        input logic [COORD_W-1:0] x,
                                        input logic [COORD_W-1:0] y);
        rect_holds = (r.lx < x) && (x < r.rx) && (r.by < y) && (y < r.ty);
    endfunction

endpackage

`default_nettype wire

// File: rtl/srs_rect_ram.sv
// Rectangle table memory: one write port, one registered read port.
`default_nettype none

module srs_rect_ram #(
    parameter int DEPTH = srs_pkg::DEF_MAX_RECTS
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  srs_pkg::t_rect           i_wr_rect,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output srs_pkg::t_rect           o_rd_rect
);
    import srs_pkg::*;

    t_rect r_mem [DEPTH];
    t_rect r_rd_rect;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_rect;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_rect <= r_mem[i_rd_addr];
    end

    assign o_rd_rect = r_rd_rect;

endmodule

`default_nettype wire

// File: rtl/stochastic_rectangle_splitter_core.sv
// Top level of the rectangle splitter: search sequencer, split writer, result register.
//
//  channel   | dir | handshake                         | payload
//  ----------+-----+-----------------------------------+----------------------------------
//  s_axis    | in  | i_s_axis_tvalid / o_s_axis_tready | tdata: point_x, point_y
//  m_axis    | out | o_m_axis_tvalid / i_m_axis_tready | tdata: entry_index, left_x,
//            |     |                                   | bottom_y, right_x, top_y,
//            |     |                                   | entries_used; tuser: status; tlast
//
// In the search the single table read port delivers one entry per cycle to one shared
// containment compare. A split then writes and reports four rectangles, one per cycle
// while m_axis keeps up. Input is taken only while the sequencer is idle; a result
// waiting in the output register does not hold off the next point, but a result stalled
// by m_axis holds the writer. After reset release the init state writes the unit square
// into entry 0, input not ready.
`default_nettype none

module stochastic_rectangle_splitter_core #(
    parameter int MAX_RECTS = srs_pkg::DEF_MAX_RECTS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [srs_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,  // point_x, point_y
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // entry_index, left_x, bottom_y, right_x, top_y, entries_used, zero pad
    output logic [srs_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    output logic [srs_pkg::STATUS_W-1:0]     o_m_axis_tuser,  // status
    output logic                             o_m_axis_tlast
);
    import srs_pkg::*;

    localparam int IW = $clog2(MAX_RECTS);
    localparam int CW = $clog2(MAX_RECTS + 1);
    localparam logic [CW-1:0] FULL_AT   = CW'(MAX_RECTS - 3);
    localparam logic [CW-1:0] CNT_ONE   = CW'(1);
    localparam logic [CW-1:0] CNT_THREE = CW'(3);
    localparam logic [IW-1:0] IDX_ONE   = IW'(1);
    localparam logic [IW-1:0] IDX_TWO   = IW'(2);

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SEARCH = 3'd2;
    localparam logic [2:0] S_RESP   = 3'd3;
    localparam logic [2:0] S_SPLIT  = 3'd4;

    logic [2:0]          r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_addr, n_addr;
    logic                r_pend, n_pend;
    logic                r_pend_last, n_pend_last;
    logic [IW-1:0]       r_cidx, n_cidx;
    logic [IW-1:0]       r_hit, n_hit;
    logic [IW-1:0]       r_n, n_n;
    logic [1:0]          r_k, n_k;
    logic [STATUS_W-1:0] r_resp_st, n_resp_st;
    logic [COORD_W-1:0]  r_x, n_x;
    logic [COORD_W-1:0]  r_y, n_y;
    t_rect               r_orig, n_orig;

    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_out_st, n_out_st;
    logic [IDX_W-1:0]    r_out_idx, n_out_idx;
    t_rect               r_out_rect, n_out_rect;
    logic [USED_W-1:0]   r_out_used, n_out_used;
    logic                r_out_last, n_out_last;

    logic                wr_en;
    logic [IW-1:0]       wr_addr;
    t_rect               wr_rect;
    t_rect               rd_rect;
    logic                hit_now;
    logic                out_free;
    logic [IW-1:0]       piece_idx;
    t_rect               piece;
    logic [IW+IDX_W-1:0] idx_ext;
    logic [IW+IDX_W-1:0] hit_ext;
    logic [CW+USED_W-1:0] used_ext;

    srs_rect_ram #(
        .DEPTH (MAX_RECTS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_rect (wr_rect),
        .i_rd_addr (r_addr[IW-1:0]),
        .o_rd_rect (rd_rect)
    );

    // Shared containment compare on the entry just read
    assign hit_now  = r_pend && rect_holds(rd_rect, r_x, r_y);
    assign out_free = !r_out_valid || i_m_axis_tready;

    // One of the four pieces of the split rectangle
    always_comb begin
        piece     = r_orig;
        piece_idx = r_hit;
        unique case (r_k)
            2'd0: begin
                piece_idx = r_hit;
                piece     = '{lx: r_orig.lx, by: r_orig.by, rx: r_x, ty: r_y};
            end
            2'd1: begin
                piece_idx = r_n;
                piece     = '{lx: r_x, by: r_orig.by, rx: r_orig.rx, ty: r_y};
            end
            2'd2: begin
                piece_idx = r_n + IDX_ONE;
                piece     = '{lx: r_x, by: r_y, rx: r_orig.rx, ty: r_orig.ty};
            end
            default: begin
                piece_idx = r_n + IDX_TWO;
                piece     = '{lx: r_orig.lx, by: r_y, rx: r_x, ty: r_orig.ty};
            end
        endcase
    end

    assign idx_ext  = {{IDX_W{1'b0}}, piece_idx};
    assign hit_ext  = {{IDX_W{1'b0}}, r_hit};
    assign used_ext = {{USED_W{1'b0}}, r_count};

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_addr      = r_addr;
        n_pend      = 1'b0;
        n_pend_last = r_pend_last;
        n_cidx      = r_cidx;
        n_hit       = r_hit;
        n_n         = r_n;
        n_k         = r_k;
        n_resp_st   = r_resp_st;
        n_x         = r_x;
        n_y         = r_y;
        n_orig      = r_orig;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_st    = r_out_st;
        n_out_idx   = r_out_idx;
        n_out_rect  = r_out_rect;
        n_out_used  = r_out_used;
        n_out_last  = r_out_last;
        wr_en       = 1'b0;
        wr_addr     = piece_idx;
        wr_rect     = piece;

        unique case (r_state)
            S_INIT: begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_rect = UNIT_RECT;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_x     = {1'b0, i_s_axis_tdata[PT_W-1:0]};
                    n_y     = {1'b0, i_s_axis_tdata[2*PT_W-1:PT_W]};
                    n_addr  = '0;
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (hit_now) begin
                    n_hit  = r_cidx;
                    n_orig = rd_rect;
                    if (r_count >= FULL_AT) begin
                        n_resp_st = ST_FULL;
                        n_state   = S_RESP;
                    end else begin
                        n_n     = r_count[IW-1:0];
                        n_count = r_count + CNT_THREE;
                        n_k     = 2'd0;
                        n_state = S_SPLIT;
                    end
                end else if (r_pend && r_pend_last) begin
                    n_resp_st = ST_NOT_FOUND;
                    n_state   = S_RESP;
                end else if (r_addr < r_count) begin
                    // issue the next read; its compare runs in the following cycle
                    n_pend      = 1'b1;
                    n_cidx      = r_addr[IW-1:0];
                    n_pend_last = (r_addr + CNT_ONE) == r_count;
                    n_addr      = r_addr + CNT_ONE;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_st    = r_resp_st;
                    n_out_used  = used_ext[USED_W-1:0];
                    n_out_last  = 1'b1;
                    if (r_resp_st == ST_FULL) begin
                        n_out_idx  = hit_ext[IDX_W-1:0];
                        n_out_rect = r_orig;
                    end else begin
                        n_out_idx  = '0;
                        n_out_rect = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            S_SPLIT: begin
                if (out_free) begin
                    wr_en       = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_st    = ST_OK;
                    n_out_idx   = idx_ext[IDX_W-1:0];
                    n_out_rect  = piece;
                    n_out_used  = used_ext[USED_W-1:0];
                    n_out_last  = (r_k == 2'd3);
                    n_k         = r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_count     <= CNT_ONE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_pend_last <= n_pend_last;
        r_cidx      <= n_cidx;
        r_hit       <= n_hit;
        r_n         <= n_n;
        r_k         <= n_k;
        r_resp_st   <= n_resp_st;
        r_x         <= n_x;
        r_y         <= n_y;
        r_orig      <= n_orig;
        r_out_st    <= n_out_st;
        r_out_idx   <= n_out_idx;
        r_out_rect  <= n_out_rect;
        r_out_used  <= n_out_used;
        r_out_last  <= n_out_last;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_st;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out_used, r_out_rect.ty, r_out_rect.rx,
                              r_out_rect.by, r_out_rect.lx, r_out_idx};

endmodule

`default_nettype wire

// File: rtl/srs_checker.sv
// Port-level checks on the rectangle splitter and their binding to the top level.
`default_nettype none

`include "stochastic_rectangle_splitter_core_defines.svh"

module srs_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_axis_tvalid,
    input logic                             o_s_axis_tready,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    // entry_index, left_x, bottom_y, right_x, top_y, entries_used, zero pad
    input logic [srs_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    input logic [srs_pkg::STATUS_W-1:0]     o_m_axis_tuser,  // status
    input logic                             o_m_axis_tlast
);
    import srs_pkg::*;

    logic [COORD_W-1:0] lx;
    logic [COORD_W-1:0] by;
    logic [COORD_W-1:0] rx;
    logic [COORD_W-1:0] ty;
    logic               in_beat;

    assign lx      = o_m_axis_tdata[OFS_LX +: COORD_W];
    assign by      = o_m_axis_tdata[OFS_BY +: COORD_W];
    assign rx      = o_m_axis_tdata[OFS_RX +: COORD_W];
    assign ty      = o_m_axis_tdata[OFS_TY +: COORD_W];
    assign in_beat = i_s_axis_tvalid && o_s_axis_tready;

    // An error result is always the only result of its point
    `SRS_ASSERT_IMP(a_err_is_last, o_m_axis_tvalid && (o_m_axis_tuser != ST_OK), o_m_axis_tlast, "error result without tlast")

    // Every split piece is a non-empty rectangle
    `SRS_ASSERT_IMP(a_piece_nonempty, o_m_axis_tvalid && (o_m_axis_tuser == ST_OK), (lx < rx) && (by < ty), "empty rectangle reported")

    `SRS_ASSERT_IMP(a_status_code, o_m_axis_tvalid, (o_m_axis_tuser == ST_OK) || (o_m_axis_tuser == ST_NOT_FOUND) || (o_m_axis_tuser == ST_FULL), "undefined status code")

    // Input ready drops after a beat while the search runs
    `SRS_ASSERT_NEXT(a_busy_after_beat, in_beat, !o_s_axis_tready, "input ready right after a beat")

    `SRS_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast), "stalled result changed")

endmodule

bind stochastic_rectangle_splitter_core srs_checker u_srs_checker (.*);

`default_nettype wire

// File: sim/tb_top.sv
// Self-checking testbench for the rectangle splitter core: stream stimulus and checker.
`timescale 1ns / 1ps

module tb_top;
    import srs_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int SETTLE_TICKS = 300;
    localparam int MAX_PRINTS   = 40;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    idx;
        t_rect               box;
        logic [USED_W-1:0]   used;
        logic                last;
    } t_rect_report;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_s_axis_tvalid;
    logic                    o_s_axis_tready;
    logic [IN_TDATA_W-1:0]   i_s_axis_tdata;   // point_x, point_y
    logic                    o_m_axis_tvalid;
    logic                    i_m_axis_tready;
    // entry_index, left_x, bottom_y, right_x, top_y, entries_used, zero pad
    logic [OUT_TDATA_W-1:0]  o_m_axis_tdata;
    logic [STATUS_W-1:0]     o_m_axis_tuser;   // status
    logic                    o_m_axis_tlast;

    // Shadow copy of the block's rectangle table
    t_rect        shadow_rects [DEF_MAX_RECTS];
    int           shadow_count;
    t_rect_report expected_reports [$];

    bit steady;
    int sink_hold_cycles;
    int mismatches;
    int n_points, n_splits, n_misses, n_full, n_checked;

    stochastic_rectangle_splitter_core #(
        .MAX_RECTS(DEF_MAX_RECTS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // No gap when steady, else: half the time none, often a short one, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 50)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic push_report(input logic [STATUS_W-1:0] status, input int idx,
                               input t_rect box, input logic last);
        t_rect_report rep;
        rep.status = status;
        rep.idx    = IDX_W'(idx);
        rep.box    = box;
        rep.used   = USED_W'(shadow_count);
        rep.last   = last;
        expected_reports.push_back(rep);
    endtask

    // Cut the first rectangle that strictly holds the point in four, or expect a miss or a full table.
    task automatic predict_split(input logic [PT_W-1:0] px, input logic [PT_W-1:0] py);
        logic [COORD_W-1:0] x, y;
        t_rect              orig;
        int                 hit, base;
        x   = {1'b0, px};
        y   = {1'b0, py};
        hit = -1;
        for (int i = 0; i < shadow_count; i++) begin
            if (hit < 0 && shadow_rects[i].lx < x && x < shadow_rects[i].rx &&
                shadow_rects[i].by < y && y < shadow_rects[i].ty)
                hit = i;
        end
        if (hit < 0) begin
            push_report(ST_NOT_FOUND, 0, '0, 1'b1);
            n_misses++;
        end else if (shadow_count + 3 >= DEF_MAX_RECTS) begin
            push_report(ST_FULL, hit, shadow_rects[hit], 1'b1);
            n_full++;
        end else begin
            orig = shadow_rects[hit];
            base = shadow_count;
            shadow_rects[base]     = '{lx: x,       by: orig.by, rx: orig.rx, ty: y};
            shadow_rects[base + 1] = '{lx: x,       by: y,       rx: orig.rx, ty: orig.ty};
            shadow_rects[base + 2] = '{lx: orig.lx, by: y,       rx: x,       ty: orig.ty};
            shadow_rects[hit].rx   = x;
            shadow_rects[hit].ty   = y;
            shadow_count           = base + 3;
            push_report(ST_OK, hit,      shadow_rects[hit],      1'b0);
            push_report(ST_OK, base,     shadow_rects[base],     1'b0);
            push_report(ST_OK, base + 1, shadow_rects[base + 1], 1'b0);
            push_report(ST_OK, base + 2, shadow_rects[base + 2], 1'b1);
            n_splits++;
        end
    endtask

    // Offer one point; tvalid stays high after the beat for back-to-back sends.
    task automatic offer_point(input logic [PT_W-1:0] px, input logic [PT_W-1:0] py);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {py, px};
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_split(px, py);
        n_points++;
    endtask

    task automatic wait_reports_done();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_reports.size() != 0) @(posedge i_clk);
    endtask

    // Pick a point strictly inside entry idx, if it is wide and tall enough.
    task automatic aim_inside(input int idx, output bit ok,
                              output logic [PT_W-1:0] px, output logic [PT_W-1:0] py);
        t_rect r;
        r  = shadow_rects[idx];
        ok = (r.rx - r.lx >= 2) && (r.ty - r.by >= 2);
        px = ok ? PT_W'($urandom_range(int'(r.rx) - 1, int'(r.lx) + 1)) : PT_W'($urandom);
        py = ok ? PT_W'($urandom_range(int'(r.ty) - 1, int'(r.by) + 1)) : PT_W'($urandom);
    endtask

    // Pick a point on the left or bottom edge of a random entry.
    task automatic aim_edge(output logic [PT_W-1:0] px, output logic [PT_W-1:0] py);
        t_rect r;
        r = shadow_rects[$urandom_range(0, shadow_count - 1)];
        if ($urandom_range(0, 1)) begin
            px = PT_W'(r.lx);
            py = PT_W'($urandom_range(r.ty > 65535 ? 65535 : int'(r.ty), int'(r.by)));
        end else begin
            py = PT_W'(r.by);
            px = PT_W'($urandom_range(r.rx > 65535 ? 65535 : int'(r.rx), int'(r.lx)));
        end
    endtask

    task automatic test_square_edges();
        offer_point(16'd0,     16'd0);
        offer_point(16'd0,     16'd12345);
        offer_point(16'd23456, 16'd0);
        offer_point(16'd32768, 16'd32768);
        offer_point(16'd32768, 16'd10000);
        offer_point(16'd10000, 16'd32768);
        offer_point(16'd40000, 16'd32768);
        offer_point(16'hFFFF,  16'hFFFF);
        offer_point(16'd1,     16'd1);
        offer_point(16'hFFFF,  16'd1);
        offer_point(16'd1,     16'hFFFF);
        offer_point(16'd0,     16'hFFFF);
        offer_point(16'hFFFF,  16'd0);
        wait_reports_done();
    endtask

    // Hold the result side off for a long stretch while points are offered without gaps.
    task automatic test_output_stall();
        logic [PT_W-1:0] px, py;
        bit              ok;
        steady           = 1'b1;
        sink_hold_cycles = 400;
        for (int k = 0; k < 8; k++) begin
            aim_inside($urandom_range(0, shadow_count - 1), ok, px, py);
            offer_point(px, py);
        end
        steady = 1'b0;
        wait_reports_done();
    endtask

    task automatic test_random_points();
        logic [PT_W-1:0] px, py;
        bit              ok;
        int              roll;
        for (int k = 0; k < 280; k++) begin
            if (k % 40 == 0)
                steady = ($urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 99);
            if (roll < 75)
                aim_inside($urandom_range(0, shadow_count - 1), ok, px, py);
            else if (roll < 88)
                aim_edge(px, py);
            else begin
                px = PT_W'($urandom);
                py = PT_W'($urandom);
            end
            offer_point(px, py);
            if (k == 140)
                wait_reports_done();
        end
        steady = 1'b0;
        wait_reports_done();
    endtask

    // Fill the table, then hit the last and the first usable entries, some edges, the origin and random points.
    task automatic test_full_table();
        logic [PT_W-1:0] px, py;
        bit              ok;
        int              guard;
        guard = 0;
        while (shadow_count + 3 < DEF_MAX_RECTS && guard < 200) begin
            aim_inside($urandom_range(0, shadow_count - 1), ok, px, py);
            if (ok)
                offer_point(px, py);
            guard++;
        end
        for (int i = shadow_count - 1; i >= 0; i--) begin
            aim_inside(i, ok, px, py);
            if (ok) begin
                offer_point(px, py);
                break;
            end
        end
        for (int i = 0; i < shadow_count; i++) begin
            aim_inside(i, ok, px, py);
            if (ok) begin
                offer_point(px, py);
                break;
            end
        end
        for (int k = 0; k < 3; k++) begin
            aim_edge(px, py);
            offer_point(px, py);
        end
        offer_point(16'd0, 16'd0);
        for (int k = 0; k < 4; k++)
            offer_point(PT_W'($urandom), PT_W'($urandom));
        wait_reports_done();
    endtask

    // Result side: random stalls, plus a long hold when a test asks for one.
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        i_m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_hold_cycles > 0) begin
                i_m_axis_tready <= 1'b0;
                sink_hold_cycles--;
            end else if (stall_left > 0) begin
                i_m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                i_m_axis_tready <= 1'b1;
                if (!steady && $urandom_range(0, 99) < 25)
                    stall_left = pick_gap();
            end
        end
    end

    task automatic compare_field(input string fname, input logic [COORD_W-1:0] want,
                                 input logic [COORD_W-1:0] got);
        if (want !== got) begin
            if (mismatches < MAX_PRINTS)
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, fname, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : check_beats
        t_rect_report want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_reports.size() == 0) begin
                if (mismatches < MAX_PRINTS)
                    $display("%0t: unexpected result beat: expected none, actual tdata %h",
                             $time, o_m_axis_tdata);
                mismatches++;
            end else begin
                want = expected_reports.pop_front();
                compare_field("status", COORD_W'(want.status), COORD_W'(o_m_axis_tuser));
                compare_field("entry_index", COORD_W'(want.idx),
                              COORD_W'(o_m_axis_tdata[OFS_IDX +: IDX_W]));
                compare_field("left_x", want.box.lx, o_m_axis_tdata[OFS_LX +: COORD_W]);
                compare_field("bottom_y", want.box.by, o_m_axis_tdata[OFS_BY +: COORD_W]);
                compare_field("right_x", want.box.rx, o_m_axis_tdata[OFS_RX +: COORD_W]);
                compare_field("top_y", want.box.ty, o_m_axis_tdata[OFS_TY +: COORD_W]);
                compare_field("entries_used", COORD_W'(want.used),
                              COORD_W'(o_m_axis_tdata[OFS_USED +: USED_W]));
                compare_field("pad", COORD_ZERO,
                              COORD_W'(o_m_axis_tdata[OUT_TDATA_W-1 -: OUT_PAD_W]));
                compare_field("last", COORD_W'(want.last), COORD_W'(o_m_axis_tlast));
                n_checked++;
            end
        end
    end

    // End the run when no beat moves on either side for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
                (o_m_axis_tvalid && i_m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("** stochastic_rectangle_splitter_core: FAILED **");
        $finish;
    end

    initial begin : run_tests
        shadow_rects    = '{default: '0};
        shadow_rects[0] = '{lx: COORD_ZERO, by: COORD_ZERO, rx: COORD_ONE, ty: COORD_ONE};
        shadow_count    = 1;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_square_edges();
        test_output_stall();
        test_random_points();
        test_full_table();

        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (expected_reports.size() != 0) begin
            $display("%0t: %0d results still expected, actual none", $time,
                     expected_reports.size());
            mismatches++;
        end
        $display("Sent %0d points: %0d splits, %0d boundary misses, %0d full-table hits.",
                 n_points, n_splits, n_misses, n_full);
        $display("Checked %0d result beats, table ended at %0d entries, %0d mismatches.",
                 n_checked, shadow_count, mismatches);
        if (mismatches == 0)
            $display("** stochastic_rectangle_splitter_core: PASSED **");
        else
            $display("** stochastic_rectangle_splitter_core: FAILED **");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/srs_pkg.sv
rtl/srs_rect_ram.sv
rtl/stochastic_rectangle_splitter_core.sv
rtl/srs_checker.sv
sim/tb_top.sv
